### rtl/core/vnh_pkg.sv
// ----------------------------------------------------------------------------
// vnh_pkg
// shared types, register indexes and the fixed hash table of the value noise
// ----------------------------------------------------------------------------
package vnh_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_HASH_SEED    = 2'd0;
  localparam logic [1:0] CFG_FREQUENCY    = 2'd1;
  localparam logic [1:0] CFG_HEIGHT_SCALE = 2'd2;

  localparam logic [7:0]  RST_HASH_SEED    = 8'd0;
  localparam logic [23:0] RST_FREQUENCY    = 24'd65536;
  localparam logic [31:0] RST_HEIGHT_SCALE = 32'd65536;

  // smoothstep numerator term 3 * 2^16
  localparam logic [17:0] SMOOTH_THREE = 18'd196608;

  typedef struct packed {
    logic        [7:0]  hash_seed;
    logic        [23:0] frequency;
    logic signed [31:0] height_scale;
  } vnh_cfg_t;

  // one classified sample: four corner bytes and the two blend weights
  typedef struct packed {
    logic [7:0]  c00;
    logic [7:0]  c10;
    logic [7:0]  c01;
    logic [7:0]  c11;
    logic [15:0] wa;
    logic [15:0] wb;
  } vnh_corner_t;

  localparam logic [7:0] PERM [256] = '{
    8'd208, 8'd34,  8'd231, 8'd213, 8'd32,  8'd248, 8'd233, 8'd56,
    8'd161, 8'd78,  8'd24,  8'd140, 8'd71,  8'd48,  8'd140, 8'd254,
    8'd245, 8'd255, 8'd247, 8'd247, 8'd40,  8'd185, 8'd248, 8'd251,
    8'd245, 8'd28,  8'd124, 8'd204, 8'd204, 8'd76,  8'd36,  8'd1,
    8'd107, 8'd28,  8'd234, 8'd163, 8'd202, 8'd224, 8'd245, 8'd128,
    8'd167, 8'd204, 8'd9,   8'd92,  8'd217, 8'd54,  8'd239, 8'd174,
    8'd173, 8'd102, 8'd193, 8'd189, 8'd190, 8'd121, 8'd100, 8'd108,
    8'd167, 8'd44,  8'd43,  8'd77,  8'd180, 8'd204, 8'd8,   8'd81,
    8'd70,  8'd223, 8'd11,  8'd38,  8'd24,  8'd254, 8'd210, 8'd210,
    8'd177, 8'd32,  8'd81,  8'd195, 8'd243, 8'd125, 8'd8,   8'd169,
    8'd112, 8'd32,  8'd97,  8'd53,  8'd195, 8'd13,  8'd203, 8'd9,
    8'd47,  8'd104, 8'd125, 8'd117, 8'd114, 8'd124, 8'd165, 8'd203,
    8'd181, 8'd235, 8'd193, 8'd206, 8'd70,  8'd180, 8'd174, 8'd0,
    8'd167, 8'd181, 8'd41,  8'd164, 8'd30,  8'd116, 8'd127, 8'd198,
    8'd245, 8'd146, 8'd87,  8'd224, 8'd149, 8'd206, 8'd57,  8'd4,
    8'd192, 8'd210, 8'd65,  8'd210, 8'd129, 8'd240, 8'd178, 8'd105,
    8'd228, 8'd108, 8'd245, 8'd148, 8'd140, 8'd40,  8'd35,  8'd195,
    8'd38,  8'd58,  8'd65,  8'd207, 8'd215, 8'd253, 8'd65,  8'd85,
    8'd208, 8'd76,  8'd62,  8'd3,   8'd237, 8'd55,  8'd89,  8'd232,
    8'd50,  8'd217, 8'd64,  8'd244, 8'd157, 8'd199, 8'd121, 8'd252,
    8'd90,  8'd17,  8'd212, 8'd203, 8'd149, 8'd152, 8'd140, 8'd187,
    8'd234, 8'd177, 8'd73,  8'd174, 8'd193, 8'd100, 8'd192, 8'd143,
    8'd97,  8'd53,  8'd145, 8'd135, 8'd19,  8'd103, 8'd13,  8'd90,
    8'd135, 8'd151, 8'd199, 8'd91,  8'd239, 8'd247, 8'd33,  8'd39,
    8'd145, 8'd101, 8'd120, 8'd99,  8'd3,   8'd186, 8'd86,  8'd99,
    8'd41,  8'd237, 8'd203, 8'd111, 8'd79,  8'd220, 8'd135, 8'd158,
    8'd42,  8'd30,  8'd154, 8'd120, 8'd67,  8'd87,  8'd167, 8'd135,
    8'd176, 8'd183, 8'd191, 8'd253, 8'd115, 8'd184, 8'd21,  8'd233,
    8'd58,  8'd129, 8'd233, 8'd142, 8'd39,  8'd128, 8'd211, 8'd118,
    8'd137, 8'd139, 8'd255, 8'd114, 8'd20,  8'd218, 8'd113, 8'd154,
    8'd27,  8'd127, 8'd246, 8'd250, 8'd1,   8'd8,   8'd198, 8'd250,
    8'd209, 8'd92,  8'd222, 8'd173, 8'd21,  8'd88,  8'd102, 8'd219
  };

  function automatic logic [7:0] perm(input logic [7:0] idx);
    perm = PERM[idx];
  endfunction

endpackage

### rtl/core/vnh_in_if.sv
// ----------------------------------------------------------------------------
// vnh_in_if
// sample channel: one coordinate pair per beat
// ----------------------------------------------------------------------------
interface vnh_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coord_a;
  logic signed [31:0] coord_b;

  modport source (output valid, output coord_a, output coord_b, input ready);
  modport sink   (input valid, input coord_a, input coord_b, output ready);
endinterface

### rtl/core/vnh_out_if.sv
// ----------------------------------------------------------------------------
// vnh_out_if
// result channel: one height per beat
// ----------------------------------------------------------------------------
interface vnh_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] height;

  modport source (output valid, output height, input ready);
  modport sink   (input valid, input height, output ready);
endinterface

### rtl/core/vnh_cfg_if.sv
// ----------------------------------------------------------------------------
// vnh_cfg_if
// configuration write channel: register index and data per beat
// ----------------------------------------------------------------------------
interface vnh_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/vnh_front.sv
// ----------------------------------------------------------------------------
// vnh_front
// scales and splits coordinates, hashes the four corners, forms the weights
// ----------------------------------------------------------------------------
module vnh_front (
  input  logic               clk,
  input  logic               rst,
  vnh_in_if.sink             sample,
  input  vnh_pkg::vnh_cfg_t  cfg_regs,
  input  logic               full,
  output logic               push,
  output vnh_pkg::vnh_corner_t item
);
  import vnh_pkg::*;

  logic               en;
  logic signed [56:0] pa;
  logic signed [56:0] pb;

  // stage 1: cell and fraction
  logic        v1;
  logic [7:0]  ca1;
  logic [7:0]  cb1;
  logic [15:0] fa1;
  logic [15:0] fb1;

  // stage 2: inner hash and squared fractions
  logic        v2;
  logic [7:0]  ca2;
  logic [7:0]  in0;
  logic [7:0]  in1;
  logic [15:0] fa2;
  logic [15:0] fb2;
  logic [31:0] fa_sq;
  logic [31:0] fb_sq;
  logic [7:0]  idx0;
  logic [7:0]  idx1;

  // stage 3: corners and weights
  logic        v3;
  logic [49:0] wa_full;
  logic [49:0] wb_full;
  logic [17:0] wa_term;
  logic [17:0] wb_term;

  assign en           = !v3 || !full;
  assign push         = v3 && !full;
  assign sample.ready = en;

  always_comb begin
    pa      = 57'(sample.coord_a) * 57'($signed({1'b0, cfg_regs.frequency}));
    pb      = 57'(sample.coord_b) * 57'($signed({1'b0, cfg_regs.frequency}));
    idx0    = cb1 + cfg_regs.hash_seed;
    idx1    = idx0 + 8'd1;
    wa_term = SMOOTH_THREE - {1'b0, fa2, 1'b0};
    wb_term = SMOOTH_THREE - {1'b0, fb2, 1'b0};
    wa_full = 50'(fa_sq) * 50'(wa_term);
    wb_full = 50'(fb_sq) * 50'(wb_term);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= sample.valid;
      v2 <= v1;
      v3 <= v2;
    end
    if (en) begin
      ca1      <= pa[39:32];
      fa1      <= pa[31:16];
      cb1      <= pb[39:32];
      fb1      <= pb[31:16];

      ca2      <= ca1;
      in0      <= perm(idx0);
      in1      <= perm(idx1);
      fa2      <= fa1;
      fb2      <= fb1;
      fa_sq    <= 32'(fa1) * 32'(fa1);
      fb_sq    <= 32'(fb1) * 32'(fb1);

      item.c00 <= perm(in0 + ca2);
      item.c10 <= perm(in0 + ca2 + 8'd1);
      item.c01 <= perm(in1 + ca2);
      item.c11 <= perm(in1 + ca2 + 8'd1);
      item.wa  <= wa_full[47:32];
      item.wb  <= wb_full[47:32];
    end
  end

endmodule

### rtl/core/vnh_queue.sv
// ----------------------------------------------------------------------------
// vnh_queue
// small register fifo between the front and back parts
// ----------------------------------------------------------------------------
module vnh_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  vnh_pkg::vnh_corner_t push_item,
  input  logic                 pop,
  output vnh_pkg::vnh_corner_t pop_item,
  output logic                 full,
  output logic                 empty
);
  import vnh_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  vnh_corner_t   mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

### rtl/core/vnh_back.sv
// ----------------------------------------------------------------------------
// vnh_back
// bilinear smoothstep blend, normalize and height scaling
// ----------------------------------------------------------------------------
module vnh_back (
  input  logic                 clk,
  input  logic                 rst,
  input  vnh_pkg::vnh_cfg_t    cfg_regs,
  input  vnh_pkg::vnh_corner_t item,
  input  logic                 empty,
  output logic                 pop,
  vnh_out_if.source            result
);
  import vnh_pkg::*;

  logic en;

  // blend along a
  logic signed [8:0]  d0;
  logic signed [8:0]  d1;
  logic signed [25:0] l0_full;
  logic signed [25:0] l1_full;
  logic               b1v;
  logic [23:0]        l0;
  logic [23:0]        l1;
  logic [15:0]        wb1;

  // blend along b
  logic signed [24:0] dl;
  logic signed [41:0] n_full;
  logic               b2v;
  logic [31:0]        v;

  // height scaling
  logic               neg;
  logic [31:0]        smag;
  logic [63:0]        prod;
  logic               b3v;
  logic               neg3;
  logic [31:0]        mag;

  assign en  = !result.valid || result.ready;
  assign pop = en && !empty;

  always_comb begin
    d0      = $signed({1'b0, item.c10}) - $signed({1'b0, item.c00});
    d1      = $signed({1'b0, item.c11}) - $signed({1'b0, item.c01});
    l0_full = $signed({2'b0, item.c00, 16'h0000})
            + 26'($signed({1'b0, item.wa})) * 26'(d0);
    l1_full = $signed({2'b0, item.c01, 16'h0000})
            + 26'($signed({1'b0, item.wa})) * 26'(d1);
    dl      = $signed({1'b0, l1}) - $signed({1'b0, l0});
    n_full  = $signed({2'b0, l0, 16'h0000})
            + 42'($signed({1'b0, wb1})) * 42'(dl);
    neg     = cfg_regs.height_scale[31];
    smag    = neg ? 32'(-cfg_regs.height_scale) : 32'(cfg_regs.height_scale);
    prod    = 64'(v) * 64'(smag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1v          <= 1'b0;
      b2v          <= 1'b0;
      b3v          <= 1'b0;
      result.valid <= 1'b0;
    end else if (en) begin
      b1v          <= !empty;
      b2v          <= b1v;
      b3v          <= b2v;
      result.valid <= b3v;
    end
    if (en) begin
      l0            <= l0_full[23:0];
      l1            <= l1_full[23:0];
      wb1           <= item.wb;
      // negative blend cannot occur, clamp kept for safety
      v             <= n_full[41] ? 32'd0 : n_full[39:8];
      mag           <= prod[63:32];
      neg3          <= neg;
      result.height <= neg3 ? -$signed(mag) : $signed(mag);
    end
  end

endmodule

### rtl/core/value_noise_height_core.sv
// ----------------------------------------------------------------------------
// value_noise_height_core
// 2-d hash-table value noise with smoothstep blend, scaled to a height
// ----------------------------------------------------------------------------
//
// channel  dir  beat contents
// -------  ---  --------------------------------------------
// sample   in   coord_a, coord_b (signed q16.16)
// result   out  height (signed q16.16)
// cfg      in   index (0 seed, 1 frequency, 2 height scale), data
//
// one sample per cycle sustained unless the queue is full; a sample beat
// passes 3 front stages, 1 queue and 4 back stages to result valid
// rst is synchronous: registers go to seed 0, frequency 1.0, scale 1.0
// and all pipeline and queue state is emptied
// a stalled result freezes only the back part; the front keeps taking
// samples until the queue between them fills
// cfg is always ready; unknown indexes are dropped
//
module value_noise_height_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  vnh_in_if.sink    sample,
  vnh_out_if.source result,
  vnh_cfg_if.sink   cfg
);
  import vnh_pkg::*;

  vnh_cfg_t    cfg_regs;
  vnh_corner_t push_item;
  vnh_corner_t pop_item;
  logic        push;
  logic        pop;
  logic        full;
  logic        empty;

  // config writes land directly in the register file
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.hash_seed    <= RST_HASH_SEED;
      cfg_regs.frequency    <= RST_FREQUENCY;
      cfg_regs.height_scale <= RST_HEIGHT_SCALE;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_HASH_SEED:    cfg_regs.hash_seed    <= cfg.data[7:0];
        CFG_FREQUENCY:    cfg_regs.frequency    <= cfg.data[23:0];
        CFG_HEIGHT_SCALE: cfg_regs.height_scale <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // front: scale, split, hash, weights
  vnh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample),
    .cfg_regs (cfg_regs),
    .full     (full),
    .push     (push),
    .item     (push_item)
  );

  // decoupling queue
  vnh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (full),
    .empty     (empty)
  );

  // back: blend, normalize, scale
  vnh_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .item     (pop_item),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

### tb/value_noise_height_core_tb.sv
// ----------------------------------------------------------------------------
// value_noise_height_core_tb
// self-checking bench for the value noise height core: an in-bench fixed-point
// height predictor fed from the accepted sample beats, an in-order height
// queue, random idling on both channels and register sweeps between phases
// ----------------------------------------------------------------------------
module value_noise_height_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vnh_pkg::*;

  // index with no register behind it, writes there must be dropped
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // smoothstep term 3.0 in q2.16
  localparam longint unsigned SMOOTH_3 = 64'd196608;

  localparam int TIMEOUT_CYCLES = 400000;
  localparam int TAIL_CYCLES    = 16;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 300;

  // corner hash table, kept independent of the package copy
  localparam logic [7:0] HASH_TAB [256] = '{
    8'd208, 8'd34,  8'd231, 8'd213, 8'd32,  8'd248, 8'd233, 8'd56,
    8'd161, 8'd78,  8'd24,  8'd140, 8'd71,  8'd48,  8'd140, 8'd254,
    8'd245, 8'd255, 8'd247, 8'd247, 8'd40,  8'd185, 8'd248, 8'd251,
    8'd245, 8'd28,  8'd124, 8'd204, 8'd204, 8'd76,  8'd36,  8'd1,
    8'd107, 8'd28,  8'd234, 8'd163, 8'd202, 8'd224, 8'd245, 8'd128,
    8'd167, 8'd204, 8'd9,   8'd92,  8'd217, 8'd54,  8'd239, 8'd174,
    8'd173, 8'd102, 8'd193, 8'd189, 8'd190, 8'd121, 8'd100, 8'd108,
    8'd167, 8'd44,  8'd43,  8'd77,  8'd180, 8'd204, 8'd8,   8'd81,
    8'd70,  8'd223, 8'd11,  8'd38,  8'd24,  8'd254, 8'd210, 8'd210,
    8'd177, 8'd32,  8'd81,  8'd195, 8'd243, 8'd125, 8'd8,   8'd169,
    8'd112, 8'd32,  8'd97,  8'd53,  8'd195, 8'd13,  8'd203, 8'd9,
    8'd47,  8'd104, 8'd125, 8'd117, 8'd114, 8'd124, 8'd165, 8'd203,
    8'd181, 8'd235, 8'd193, 8'd206, 8'd70,  8'd180, 8'd174, 8'd0,
    8'd167, 8'd181, 8'd41,  8'd164, 8'd30,  8'd116, 8'd127, 8'd198,
    8'd245, 8'd146, 8'd87,  8'd224, 8'd149, 8'd206, 8'd57,  8'd4,
    8'd192, 8'd210, 8'd65,  8'd210, 8'd129, 8'd240, 8'd178, 8'd105,
    8'd228, 8'd108, 8'd245, 8'd148, 8'd140, 8'd40,  8'd35,  8'd195,
    8'd38,  8'd58,  8'd65,  8'd207, 8'd215, 8'd253, 8'd65,  8'd85,
    8'd208, 8'd76,  8'd62,  8'd3,   8'd237, 8'd55,  8'd89,  8'd232,
    8'd50,  8'd217, 8'd64,  8'd244, 8'd157, 8'd199, 8'd121, 8'd252,
    8'd90,  8'd17,  8'd212, 8'd203, 8'd149, 8'd152, 8'd140, 8'd187,
    8'd234, 8'd177, 8'd73,  8'd174, 8'd193, 8'd100, 8'd192, 8'd143,
    8'd97,  8'd53,  8'd145, 8'd135, 8'd19,  8'd103, 8'd13,  8'd90,
    8'd135, 8'd151, 8'd199, 8'd91,  8'd239, 8'd247, 8'd33,  8'd39,
    8'd145, 8'd101, 8'd120, 8'd99,  8'd3,   8'd186, 8'd86,  8'd99,
    8'd41,  8'd237, 8'd203, 8'd111, 8'd79,  8'd220, 8'd135, 8'd158,
    8'd42,  8'd30,  8'd154, 8'd120, 8'd67,  8'd87,  8'd167, 8'd135,
    8'd176, 8'd183, 8'd191, 8'd253, 8'd115, 8'd184, 8'd21,  8'd233,
    8'd58,  8'd129, 8'd233, 8'd142, 8'd39,  8'd128, 8'd211, 8'd118,
    8'd137, 8'd139, 8'd255, 8'd114, 8'd20,  8'd218, 8'd113, 8'd154,
    8'd27,  8'd127, 8'd246, 8'd250, 8'd1,   8'd8,   8'd198, 8'd250,
    8'd209, 8'd92,  8'd222, 8'd173, 8'd21,  8'd88,  8'd102, 8'd219
  };

  logic clk = 1'b0;
  logic rst;

  vnh_in_if  sample_if ();
  vnh_out_if result_if ();
  vnh_cfg_if cfg_if ();

  value_noise_height_core u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  // shadow of the register file, starts at the reset values
  logic        [7:0]  seed_reg  = 8'd0;
  logic        [23:0] freq_reg  = 24'h010000;
  logic signed [31:0] scale_reg = 32'sh0001_0000;

  // heights still owed by the core, oldest first
  logic signed [31:0] height_q [$];

  int   mismatch_count = 0;
  int   cycle_count    = 0;
  bit   no_idle        = 1'b0;   // set for back-to-back stretches on both sides
  int   rx_hold        = 0;
  logic take_result    = 1'b0;
  logic signed [31:0] want_height;

  assign result_if.ready = take_result;

  initial begin
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // height predictor
  // --------------------------------------------------------------------------

  // smoothstep weight s*s*(3-2s) on a q0.16 fraction, floored to q0.16
  function automatic logic [15:0] smooth_weight(input logic [15:0] frac);
    longint unsigned f;
    f = 64'(frac);
    return 16'((f * f * (SMOOTH_3 - 64'd2 * f)) >> 32);
  endfunction

  // two-level table hash of one cell corner, seed offsets the b cell
  function automatic longint corner_byte(input logic [7:0] cell_a, input logic [7:0] cell_b);
    logic [7:0] inner;
    inner = HASH_TAB[8'(cell_b + seed_reg)];
    return longint'(HASH_TAB[8'(inner + cell_a)]);
  endfunction

  function automatic logic signed [31:0] noise_height(input logic signed [31:0] coord_a,
                                                      input logic signed [31:0] coord_b);
    longint            pa, pb, c00, c10, c01, c11, l0, l1, n, s;
    logic [7:0]        ca, cb;
    logic [15:0]       wa, wb;
    longint unsigned   v, smag, mag;
    // scale both coordinates, q16.16 times q8.16 lands in q24.32
    pa = longint'(coord_a) * longint'({8'd0, freq_reg});
    pb = longint'(coord_b) * longint'({8'd0, freq_reg});
    // floor cell kept mod 256, fraction from bits 31..16
    ca = pa[39:32];
    cb = pb[39:32];
    wa = smooth_weight(pa[31:16]);
    wb = smooth_weight(pb[31:16]);
    c00 = corner_byte(ca, cb);
    c10 = corner_byte(8'(ca + 8'd1), cb);
    c01 = corner_byte(ca, 8'(cb + 8'd1));
    c11 = corner_byte(8'(ca + 8'd1), 8'(cb + 8'd1));
    // blend along a in q8.16, then along b in q8.32
    l0 = c00 * 64'sd65536 + longint'({48'd0, wa}) * (c10 - c00);
    l1 = c01 * 64'sd65536 + longint'({48'd0, wa}) * (c11 - c01);
    n  = l0 * 64'sd65536 + longint'({48'd0, wb}) * (l1 - l0);
    if (n < 0) begin
      n = 0;
    end
    // divide by 256, then scale with truncation toward zero
    v    = 64'(n) >> 8;
    s    = longint'(scale_reg);
    smag = (s < 0) ? 64'(-s) : 64'(s);
    mag  = (v * smag) >> 32;
    return (s < 0) ? 32'(-longint'(mag)) : 32'(mag);
  endfunction

  // --------------------------------------------------------------------------
  // shared helpers
  // --------------------------------------------------------------------------

  function automatic int idle_gap();
    return no_idle ? 0 : int'($urandom_range(0, 14));
  endfunction

  task automatic report_mismatch(input string what, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("height mismatch (%s): expected %0d (%h) got %0d (%h)",
               what, want, want, got, got);
    end
  endtask

  // one sample beat; valid stays up afterwards so gap-free beats run back to back
  task automatic send_sample(input logic signed [31:0] coord_a,
                             input logic signed [31:0] coord_b);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_if.valid   <= 1'b1;
    sample_if.coord_a <= coord_a;
    sample_if.coord_b <= coord_b;
    do @(posedge clk); while (!sample_if.ready);
    height_q.push_back(noise_height(coord_a, coord_b));
  endtask

  // stop sending and hold off until every owed height has come back
  task automatic wait_drained();
    sample_if.valid <= 1'b0;
    while (height_q.size() != 0) @(posedge clk);
  endtask

  // one register beat; caller lowers valid after the last one
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_HASH_SEED:    seed_reg  = data[7:0];
      CFG_FREQUENCY:    freq_reg  = data[23:0];
      CFG_HEIGHT_SCALE: scale_reg = data;
      default: ;  // unmapped index, nothing changes
    endcase
  endtask

  // full register update while the core is idle, upper seed and frequency data bits carry junk
  task automatic apply_cfg(input logic [7:0] seed, input logic [23:0] freq,
                           input logic [31:0] scale, input bit stray);
    wait_drained();
    cfg_write(CFG_HASH_SEED, {24'($urandom), seed});
    if (stray) begin
      cfg_write(CFG_UNUSED, $urandom);
    end
    cfg_write(CFG_FREQUENCY, {8'($urandom), freq});
    cfg_write(CFG_HEIGHT_SCALE, scale);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_coord();
    logic signed [31:0] c;
    case ($urandom_range(0, 3))
      0: c = $urandom;
      // within eight cells of the origin, both signs
      1: c = $signed(32'($urandom_range(0, 1048575))) - 32'sd524288;
      // a few lsbs around a cell edge
      2: c = $signed({16'($urandom), 16'h0000}) + $signed(32'($urandom_range(0, 6))) - 32'sd3;
      default: begin
        case ($urandom_range(0, 5))
          0: c = 32'sh7FFF_FFFF;
          1: c = 32'sh8000_0000;
          2: c = 32'sh0000_0000;
          3: c = 32'shFFFF_FFFF;
          4: c = 32'sh0000_FFFF;
          default: c = 32'sh0001_0000;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [23:0] pick_freq();
    logic [23:0] f;
    case ($urandom_range(0, 4))
      0: f = 24'($urandom);
      1: f = 24'(32'd63488 + $urandom_range(0, 4095));   // close to 1.0
      2: f = 24'($urandom_range(0, 65535));              // below 1.0
      3: f = $urandom_range(0, 1) ? 24'hFF_FFFF : 24'h00_0000;
      default: f = 24'($urandom_range(1, 16)) << 16;     // whole multiples
    endcase
    return f;
  endfunction

  function automatic logic [31:0] pick_scale();
    logic [31:0] s;
    case ($urandom_range(0, 2))
      0: s = $urandom;
      1: s = 32'($signed(32'($urandom_range(0, 524288))) - 32'sd262144);
      default: begin
        case ($urandom_range(0, 4))
          0: s = 32'h7FFF_FFFF;
          1: s = 32'h8000_0000;
          2: s = 32'h0000_0000;
          3: s = 32'hFFFF_FFFF;
          default: s = 32'h0001_0000;
        endcase
      end
    endcase
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // result side: random stall after each beat, in-order compare
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      if (height_q.size() == 0) begin
        report_mismatch("no height owed", 32'sd0, result_if.height);
      end else begin
        want_height = height_q.pop_front();
        if (result_if.height !== want_height) begin
          report_mismatch("wrong height", want_height, result_if.height);
        end
      end
      rx_hold = idle_gap();
    end else if (rx_hold > 0) begin
      rx_hold--;
    end
    take_result <= (rx_hold == 0);
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset settings: seed 0, frequency 1.0, scale 1.0
  task automatic test_reset_defaults();
    send_sample(32'sh0000_0000, 32'sh0000_0000);
    send_sample(32'sh0000_8000, 32'sh0000_4000);
    // negative coordinates floor to the cell below
    send_sample(32'shFFFF_8000, 32'shFFFF_C000);
    send_sample(32'shFFFF_FFFF, 32'shFFFF_FFFF);
    send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000, 32'sh8000_0000);
    // cell 255 next to cell 256, hash index wraps
    send_sample(32'sh00FF_8000, 32'sh0100_8000);
    send_sample(32'sh7FFF_FFFF, 32'sh8000_0000);
  endtask

  // register extremes, including a write to the unmapped index
  task automatic test_register_extremes();
    // largest frequency makes large products whose upper cell bits drop out
    apply_cfg(8'hFF, 24'hFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_sample(32'sh1234_5678, 32'shFEDC_BA98);
    send_sample(32'shFFFF_FFFF, 32'sh0000_0001);
    send_sample(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_sample(32'sh0001_0000, 32'shFFFF_0000);
    // zero frequency pins every sample to cell zero, most negative scale
    apply_cfg(8'h00, 24'h00_0000, 32'h8000_0000, 1'b1);
    send_sample(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_sample(32'sh5555_AAAA, 32'shAAAA_5555);
    send_sample(32'sh0000_0000, 32'sh0000_0000);
    // smallest nonzero frequency, scale of minus one lsb
    apply_cfg(8'h80, 24'h00_0001, 32'hFFFF_FFFF, 1'b0);
    send_sample(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_sample(32'sh1234_0000, 32'shEDCC_0000);
    // zero scale flattens everything
    apply_cfg(8'h01, 24'h80_0000, 32'h0000_0000, 1'b0);
    send_sample(32'sh0003_2000, 32'shFFFC_E000);
    send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    // fractional frequency, scale of minus one
    apply_cfg(8'h5A, 24'h01_8000, 32'hFFFF_0000, 1'b1);
    send_sample(32'sh0000_AAAA, 32'sh0000_5555);
    send_sample(32'shFFFE_1234, 32'sh0002_EDCB);
    send_sample(32'sh00AA_FFFF, 32'shFF55_0001);
    send_sample(32'sh8000_0001, 32'sh7FFF_FFFE);
  endtask

  // random phases, each under its own register setting
  task automatic test_random_sweep();
    for (int phase = 0; phase < PHASES; phase++) begin
      no_idle = (phase == 1);
      apply_cfg(8'($urandom), pick_freq(), pick_scale(), 1'($urandom_range(0, 1)));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // sender holds off mid-phase until the pipeline has emptied
        if (phase == 3 && i == PHASE_ITEMS / 2) begin
          wait_drained();
        end
        send_sample(pick_coord(), pick_coord());
      end
    end
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // run control
  // --------------------------------------------------------------------------
  initial begin
    rst               <= 1'b1;
    sample_if.valid   <= 1'b0;
    sample_if.coord_a <= '0;
    sample_if.coord_b <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= CFG_HASH_SEED;
    cfg_if.data       <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_random_sweep();

    // drain, then leave room for any stray beat past the last height
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hang guard
  initial begin
    while (cycle_count < TIMEOUT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

endmodule
